[rtl/core/z_buffer_depth_test_core_defines.svh]
// Assertion macros shared by the depth test core RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef Z_BUFFER_DEPTH_TEST_CORE_DEFINES_SVH
`define Z_BUFFER_DEPTH_TEST_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ZBD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ZBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/zbd_pkg.sv]
// Shared types and constants of the depth test core.
// Depends on nothing; imported by every module in rtl/core.
package zbd_pkg;

    localparam int COEF_W  = 32;
    localparam int DEPTH_W = 16;
    localparam int SURF_W  = 4;
    localparam int POS_W   = 6;
    localparam int FAR_RESET = 1000;
    localparam int ONE_Q16   = 65536;

    typedef enum logic [1:0] {
        OP_FRAG  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STAT_WRITTEN = 2'd0,
        STAT_HIDDEN  = 2'd1,
        STAT_FAULT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_LOOK,
        CS_EVAL,
        CS_DONE
    } t_core_state;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_SUM,
        ES_ABS,
        ES_CHK,
        ES_DIV,
        ES_FIN
    } t_eval_state;

    typedef struct packed {
        logic [SURF_W-1:0]         surf;
        logic signed [DEPTH_W-1:0] depth;
    } t_pix;

    typedef struct packed {
        logic                     start;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic [POS_W-1:0]         px;
        logic [POS_W-1:0]         py;
    } t_eval_req;

    typedef struct packed {
        logic                      done;
        logic signed [DEPTH_W-1:0] z;
    } t_eval_rsp;

endpackage

[rtl/core/zbd_store.sv]
// Pixel store: one write port, one read port, registered read data.
// Depends on zbd_pkg for the pixel entry type.
module zbd_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  zbd_pkg::t_pix        i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output zbd_pkg::t_pix        o_rd_data
);
    import zbd_pkg::*;

    t_pix r_mem [DEPTH];
    t_pix r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/zbd_plane_eval.sv]
// Plane depth unit: z = (1 - a*x - b*y) / c, truncated and saturated to 16 bits.
// Depends on zbd_pkg; products, sum and a serial restoring divider.
module zbd_plane_eval (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  zbd_pkg::t_eval_req   i_req,
    output zbd_pkg::t_eval_rsp   o_rsp
);
    import zbd_pkg::*;

    localparam int PROD_W = COEF_W + POS_W + 1;
    localparam int NUM_W  = PROD_W + 2;
    localparam int QUO_W  = DEPTH_W + 1;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam logic signed [DEPTH_W-1:0] Z_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] Z_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] Q_POS_LIM = QUO_W'(2 ** (DEPTH_W - 1) - 1);
    localparam logic [QUO_W-1:0] Q_NEG_LIM = QUO_W'(2 ** (DEPTH_W - 1));

    t_eval_state r_state, n_state;

    logic signed [PROD_W-1:0] r_pa, r_pb;
    logic signed [COEF_W-1:0] r_c;
    logic signed [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]         r_nmag;
    logic [COEF_W-1:0]        r_cmag;
    logic                     r_neg;
    logic                     r_ovf;
    logic [COEF_W-1:0]        r_rem;
    logic [QUO_W-1:0]         r_low;
    logic [QUO_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [NUM_W-1:0]  w_num;
    logic [COEF_W:0]          w_trial;
    logic                     w_qbit;
    logic [QUO_W-1:0]         w_quo_neg;
    logic signed [DEPTH_W-1:0] w_z;

    assign w_num = NUM_W'(ONE_Q16)
                 - {{(NUM_W-PROD_W){r_pa[PROD_W-1]}}, r_pa}
                 - {{(NUM_W-PROD_W){r_pb[PROD_W-1]}}, r_pb};

    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_cmag});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ES_IDLE: begin
                if (i_req.start) begin
                    n_state = ES_SUM;
                end
            end
            ES_SUM: n_state = ES_ABS;
            ES_ABS: n_state = ES_CHK;
            ES_CHK: begin
                // quotient too large for 17 bits: skip the divide, saturate
                n_state = ({{(COEF_W-HI_W){1'b0}}, r_nmag[NUM_W-1:QUO_W]} >= r_cmag)
                        ? ES_FIN : ES_DIV;
            end
            ES_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ES_FIN;
                end
            end
            ES_FIN:  n_state = ES_IDLE;
            default: n_state = ES_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ES_IDLE: begin
                r_pa <= PROD_W'(i_req.coef_a) * PROD_W'($signed({1'b0, i_req.px}));
                r_pb <= PROD_W'(i_req.coef_b) * PROD_W'($signed({1'b0, i_req.py}));
                r_c  <= i_req.coef_c;
            end
            ES_SUM: begin
                r_num <= w_num;
            end
            ES_ABS: begin
                r_nmag <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
                r_cmag <= r_c[COEF_W-1] ? COEF_W'(-r_c) : COEF_W'(r_c);
                r_neg  <= r_num[NUM_W-1] ^ r_c[COEF_W-1];
            end
            ES_CHK: begin
                r_ovf <= ({{(COEF_W-HI_W){1'b0}}, r_nmag[NUM_W-1:QUO_W]} >= r_cmag);
                r_rem <= {{(COEF_W-HI_W){1'b0}}, r_nmag[NUM_W-1:QUO_W]};
                r_low <= r_nmag[QUO_W-1:0];
                r_quo <= '0;
                r_cnt <= CNT_W'(QUO_W - 1);
            end
            ES_DIV: begin
                r_rem <= w_qbit ? COEF_W'(w_trial - {1'b0, r_cmag}) : w_trial[COEF_W-1:0];
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], w_qbit};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // saturate the signed quotient to the depth range
    assign w_quo_neg = ~r_quo + 1'b1;

    always_comb begin
        if (r_ovf) begin
            w_z = r_neg ? Z_MIN : Z_MAX;
        end else if (r_neg) begin
            w_z = (r_quo > Q_NEG_LIM) ? Z_MIN : w_quo_neg[DEPTH_W-1:0];
        end else begin
            w_z = (r_quo > Q_POS_LIM) ? Z_MAX : r_quo[DEPTH_W-1:0];
        end
    end

    assign o_rsp.done = (r_state == ES_FIN);
    assign o_rsp.z    = w_z;

endmodule

[rtl/core/z_buffer_depth_test_core.sv]
// Depth test core top level: request control, pixel store and plane depth unit.
// Depends on zbd_pkg, zbd_store, zbd_plane_eval and the assertion macro header.
//
//  port group       | dir | payload (low bit first)
//  -----------------+-----+-----------------------------------------------------
//  s_axis_*         | in  | tuser: op; tdata: pixel_x, pixel_y, surface,
//                   |     |        coef_a, coef_b, coef_c
//  m_axis_*         | out | tuser: status; tdata: surface_at_pixel, depth_at_pixel
//  i_cfg_wr_*       | in  | far_depth, written whenever i_cfg_wr_en is high
//
// A read or an unused op passes through the lookup and done states after accept; a
// fragment whose depth is computed also waits on the depth unit, mostly on the 17
// steps of its serial divider, which are skipped when the quotient overflows; a clear
// sweeps the store, one store entry written per cycle. Reset starts the same sweep
// over the store with depth 1000; no request is taken until it ends.
// A result waits in the output register while the next request is accepted.
`include "z_buffer_depth_test_core_defines.svh"

module z_buffer_depth_test_core #(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64,
    parameter int MAX_SURFACES = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,   // pixel_x, pixel_y, surface, coef_a, coef_b, coef_c
    input  logic [1:0]   s_axis_tuser,   // op
    // result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // surface_at_pixel, depth_at_pixel, zero fill
    output logic [1:0]   m_axis_tuser,   // status
    // far depth register
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);
    import zbd_pkg::*;

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);

    // request fields
    logic [POS_W-1:0]          w_px, w_py;
    logic [SURF_W-1:0]         w_surf;
    logic                      w_inside;
    logic [ADDR_W-1:0]         w_addr;
    logic                      w_in_accept;
    logic                      w_in_ready;

    t_core_state               r_state, n_state;
    logic [ADDR_W-1:0]         r_sweep_cnt, n_sweep_cnt;
    logic                      r_clr_op, n_clr_op;
    logic signed [DEPTH_W-1:0] r_far_depth;
    logic signed [DEPTH_W-1:0] r_sweep_val;

    logic [1:0]                r_op;
    logic                      r_inside;
    logic [ADDR_W-1:0]         r_addr;
    logic [SURF_W-1:0]         r_surf;
    logic signed [COEF_W-1:0]  r_coef_a, r_coef_b, r_coef_c;
    logic [POS_W-1:0]          r_px, r_py;

    t_status                   r_res_status, n_res_status;
    logic [SURF_W-1:0]         r_res_surf, n_res_surf;
    logic signed [DEPTH_W-1:0] r_res_depth, n_res_depth;

    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [SURF_W-1:0]         r_out_surf;
    logic signed [DEPTH_W-1:0] r_out_depth;
    logic                      w_load_out;

    logic                      w_wr_en;
    logic [ADDR_W-1:0]         w_wr_addr;
    t_pix                      w_wr_data;
    t_pix                      w_rd_pix;

    logic                      w_eval_start;
    t_eval_req                 w_eval_req;
    t_eval_rsp                 w_eval_rsp;

    // unpack the request and locate the pixel
    assign w_px   = s_axis_tdata[5:0];
    assign w_py   = s_axis_tdata[11:6];
    assign w_surf = (32'(s_axis_tdata[15:12]) > 32'(MAX_SURFACES))
                  ? SURF_W'(MAX_SURFACES) : s_axis_tdata[15:12];
    assign w_inside = (32'(w_px) < 32'(FRAME_WIDTH)) && (32'(w_py) < 32'(FRAME_HEIGHT));
    assign w_addr = w_inside
                  ? ADDR_W'(ADDR_W'(w_px) + ADDR_W'(w_py) * ADDR_W'(FRAME_WIDTH)) : '0;

    assign w_in_ready  = (r_state == CS_IDLE);
    assign w_in_accept = s_axis_tvalid && w_in_ready;

    // far depth register; the user is to write it only while the core is quiet, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far_depth <= DEPTH_W'(FAR_RESET);
        end else if (i_cfg_wr_en) begin
            r_far_depth <= i_cfg_wr_data;
        end
    end

    // sweep value: 1000 after reset, the far depth at the time of a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_val <= DEPTH_W'(FAR_RESET);
        end else if (w_in_accept && (s_axis_tuser == OP_CLEAR)) begin
            r_sweep_val <= r_far_depth;
        end
    end

    // hold the accepted request for the whole operation
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op     <= s_axis_tuser;
            r_inside <= w_inside;
            r_addr   <= w_addr;
            r_surf   <= w_surf;
            r_px     <= w_px;
            r_py     <= w_py;
            r_coef_a <= s_axis_tdata[47:16];
            r_coef_b <= s_axis_tdata[79:48];
            r_coef_c <= s_axis_tdata[111:80];
        end
    end

    // control: next state, store writes, result staging
    always_comb begin
        n_state      = r_state;
        n_sweep_cnt  = r_sweep_cnt;
        n_clr_op     = r_clr_op;
        n_res_status = r_res_status;
        n_res_surf   = r_res_surf;
        n_res_depth  = r_res_depth;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_addr;
        w_wr_data    = '{surf: r_surf, depth: w_eval_rsp.z};
        w_eval_start = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            CS_CLEAR: begin
                // write one entry per cycle with the sweep value and no surface
                w_wr_en     = 1'b1;
                w_wr_addr   = r_sweep_cnt;
                w_wr_data   = '{surf: '0, depth: r_sweep_val};
                n_sweep_cnt = r_sweep_cnt + 1'b1;
                if (r_sweep_cnt == SWEEP_LAST) begin
                    n_sweep_cnt = '0;
                    n_state     = r_clr_op ? CS_DONE : CS_IDLE;
                end
            end
            CS_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_CLEAR) begin
                        n_clr_op     = 1'b1;
                        n_res_status = STAT_WRITTEN;
                        n_res_surf   = '0;
                        n_res_depth  = r_far_depth;
                        n_state      = CS_CLEAR;
                    end else begin
                        n_state = CS_LOOK;
                    end
                end
            end
            CS_LOOK: begin
                // stored pixel is on the read port now
                n_state      = CS_DONE;
                n_res_status = STAT_WRITTEN;
                n_res_surf   = r_inside ? w_rd_pix.surf : '0;
                n_res_depth  = r_inside ? w_rd_pix.depth : '0;
                case (r_op)
                    OP_FRAG: begin
                        if (r_coef_c == '0) begin
                            n_res_status = STAT_FAULT;
                        end else if (!r_inside) begin
                            n_res_status = STAT_HIDDEN;
                        end else begin
                            w_eval_start = 1'b1;
                            n_state      = CS_EVAL;
                        end
                    end
                    OP_READ: begin
                    end
                    default: begin
                        // unused op: every field zero
                        n_res_surf  = '0;
                        n_res_depth = '0;
                    end
                endcase
            end
            CS_EVAL: begin
                if (w_eval_rsp.done) begin
                    n_state = CS_DONE;
                    if (w_eval_rsp.z < w_rd_pix.depth) begin
                        w_wr_en      = 1'b1;
                        n_res_status = STAT_WRITTEN;
                        n_res_surf   = r_surf;
                        n_res_depth  = w_eval_rsp.z;
                    end else begin
                        n_res_status = STAT_HIDDEN;
                        n_res_surf   = w_rd_pix.surf;
                        n_res_depth  = w_rd_pix.depth;
                    end
                end
            end
            CS_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_clr_op   = 1'b0;
                    n_state    = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_CLEAR;
            r_sweep_cnt <= '0;
            r_clr_op    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_cnt <= n_sweep_cnt;
            r_clr_op    <= n_clr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_surf   <= n_res_surf;
        r_res_depth  <= n_res_depth;
    end

    // output register: advance on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_surf   <= r_res_surf;
            r_out_depth  <= r_res_depth;
        end
    end

    zbd_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_pix)
    );

    assign w_eval_req = '{
        start:  w_eval_start,
        coef_a: r_coef_a,
        coef_b: r_coef_b,
        coef_c: r_coef_c,
        px:     r_px,
        py:     r_py
    };

    zbd_plane_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_eval_req),
        .o_rsp   (w_eval_rsp)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0000, r_out_depth, r_out_surf};

    // a depth write outside the sweep only accompanies a finished depth evaluation
    `ZBD_ASSERT_SAME(a_frag_write_src, w_wr_en && (r_state != CS_CLEAR), w_eval_rsp.done, "store write without evaluated depth")
    // the depth unit reports only while the core waits for it
    `ZBD_ASSERT_SAME(a_eval_done_state, w_eval_rsp.done, r_state == CS_EVAL, "depth result outside evaluation")
    // an accepted request always leaves the idle state
    `ZBD_ASSERT_NEXT(a_accept_busy, w_in_accept, r_state != CS_IDLE, "request accepted but core stayed idle")
    // a new result appears only from the handover state
    `ZBD_ASSERT_NEXT(a_out_from_done, w_load_out, m_axis_tvalid && (r_state == CS_IDLE), "result handover lost")

endmodule
